@@ sv/tcw_pkg.sv @@
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL   = {ATTR_RESET, SPACE_CODE};

    // Command to the sweep engine: fill the whole store, or scroll up one row
    typedef struct packed {
        logic              go;
        logic              scroll;
        logic [CELL_W-1:0] fill;
    } tcw_sweep_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tcw_sweep_stat_t;

endpackage

@@ sv/tcw_ram.sv @@
module tcw_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2000,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/tcw_sweep.sv @@
module tcw_sweep
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF,
    localparam int CELLS      = COLUMNS * ROWS,
    localparam int COPY_CELLS = (ROWS - 1) * COLUMNS,
    localparam int ADDR_W     = $clog2(CELLS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tcw_sweep_cmd_t    cmd,
    output tcw_sweep_stat_t   stat,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [CELL_W-1:0] ram_wdata,
    output logic [ADDR_W-1:0] ram_raddr,
    input  logic [CELL_W-1:0] ram_rdata
);

    logic [ADDR_W-1:0] cnt_reg;
    logic              active_reg;
    logic              scroll_reg;
    logic [CELL_W-1:0] fill_reg;
    logic              wr_valid_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic              wr_fill_reg;
    logic              copy_now;

    // Rows above the bottom one take the cell one row below; the rest fill
    assign copy_now  = scroll_reg && (32'(cnt_reg) < COPY_CELLS);
    assign ram_raddr = copy_now ? ADDR_W'(32'(cnt_reg) + COLUMNS) : cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            wr_valid_reg <= 1'b0;
        end else begin
            wr_valid_reg <= active_reg;
            if (cmd.go) begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
                scroll_reg <= cmd.scroll;
                fill_reg   <= cmd.fill;
            end else if (active_reg) begin
                cnt_reg <= ADDR_W'(32'(cnt_reg) + 1);
                if (32'(cnt_reg) == CELLS - 1) begin
                    active_reg <= 1'b0;
                end
            end
        end
        wr_addr_reg <= cnt_reg;
        wr_fill_reg <= !copy_now;
    end

    assign ram_we    = wr_valid_reg;
    assign ram_waddr = wr_addr_reg;
    assign ram_wdata = wr_fill_reg ? fill_reg : ram_rdata;

    assign stat.busy = active_reg || wr_valid_reg;
    assign stat.done = wr_valid_reg && !active_reg;

endmodule

@@ sv/text_console_writer.sv @@
// Channel   Direction  Ports                                      Transfer when
// s_        in         s_op, s_char_code, s_cell_index            s_valid & s_ready
// m_        out        m_cursor_pos, m_cell_value                 m_valid & m_ready
// cfg_      in         cfg_color_attr                             cfg_valid & cfg_ready
//
// Puts pass ST_EXEC and ST_RESULT, reads also ST_RDWAIT; ST_RESULT waits for the m_ slot.
// During a scroll or a clear the sweep engine moves one cell a cycle
// through the single read and single write port of the screen RAM.
// After reset the sweep engine fills the screen RAM and s_ready stays low; configuration
// transfers are taken at all times.
// A stalled m_ is held in the output register; s_ stays low until the block is back in idle.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_op,
    input  logic [CHAR_W-1:0] s_char_code,
    input  logic [IDX_W-1:0]  s_cell_index,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [POS_W-1:0]  m_cursor_pos,
    output logic [CELL_W-1:0] m_cell_value,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ATTR_W-1:0] cfg_color_attr
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_INIT_WAIT,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SWEEP,
        ST_RESULT
    } state_t;

    state_t            state_reg;
    logic [ATTR_W-1:0] attr_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ADDR_W-1:0] row_base_reg;
    logic [OP_W-1:0]   op_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CELL_W-1:0] value_reg;
    logic              m_valid_reg;
    logic [POS_W-1:0]  m_cursor_pos_reg;
    logic [CELL_W-1:0] m_cell_value_reg;
    tcw_sweep_cmd_t    sw_cmd_reg;

    tcw_sweep_stat_t   sw_stat;
    logic              sw_we;
    logic [ADDR_W-1:0] sw_waddr;
    logic [CELL_W-1:0] sw_wdata;
    logic [ADDR_W-1:0] sw_raddr;

    logic              top_we;
    logic [ADDR_W-1:0] cursor_addr;
    logic [CELL_W-1:0] ram_rdata;
    logic [31:0]       pos_full;
    logic              is_newline;
    logic              wrap;
    logic              last_row;
    logic              idx_in_range;

    assign cursor_addr  = ADDR_W'(32'(row_base_reg) + 32'(col_reg));
    assign pos_full     = 32'(row_base_reg) + 32'(col_reg);
    assign is_newline   = (char_reg == NEWLINE_CODE);
    assign wrap         = is_newline || (32'(col_reg) == COLUMNS - 1);
    assign last_row     = (32'(row_reg) == ROWS - 1);
    assign idx_in_range = (32'(idx_reg) < CELLS);
    assign top_we       = (state_reg == ST_EXEC) && (op_reg == OP_PUT) && !is_newline;

    tcw_sweep #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_sweep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (sw_cmd_reg),
        .stat      (sw_stat),
        .ram_we    (sw_we),
        .ram_waddr (sw_waddr),
        .ram_wdata (sw_wdata),
        .ram_raddr (sw_raddr),
        .ram_rdata (ram_rdata)
    );

    tcw_ram #(
        .DATA_W (CELL_W),
        .DEPTH  (CELLS)
    ) u_screen (
        .aclk  (aclk),
        .we    (sw_we || top_we),
        .waddr (sw_we ? sw_waddr : cursor_addr),
        .wdata (sw_we ? sw_wdata : {attr_reg, char_reg}),
        .raddr (sw_stat.busy ? sw_raddr : ADDR_W'(idx_reg)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            attr_reg      <= ATTR_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            row_base_reg  <= '0;
            m_valid_reg   <= 1'b0;
            sw_cmd_reg.go <= 1'b0;
        end else begin
            sw_cmd_reg.go <= 1'b0;
            if (cfg_valid) begin
                attr_reg <= cfg_color_attr;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_INIT: begin
                    sw_cmd_reg.go     <= 1'b1;
                    sw_cmd_reg.scroll <= 1'b0;
                    sw_cmd_reg.fill   <= RESET_CELL;
                    state_reg         <= ST_INIT_WAIT;
                end
                ST_INIT_WAIT: begin
                    if (sw_stat.done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= s_op;
                        char_reg  <= s_char_code;
                        idx_reg   <= s_cell_index;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    value_reg <= '0;
                    state_reg <= ST_RESULT;
                    case (op_reg)
                        OP_PUT: begin
                            if (!wrap) begin
                                col_reg <= COL_W'(32'(col_reg) + 1);
                            end else begin
                                col_reg <= '0;
                                if (last_row) begin
                                    // stay on the bottom row, shift the screen up
                                    sw_cmd_reg.go     <= 1'b1;
                                    sw_cmd_reg.scroll <= 1'b1;
                                    sw_cmd_reg.fill   <= {attr_reg, SPACE_CODE};
                                    state_reg         <= ST_SWEEP;
                                end else begin
                                    row_reg      <= ROW_W'(32'(row_reg) + 1);
                                    row_base_reg <= ADDR_W'(32'(row_base_reg) + COLUMNS);
                                end
                            end
                        end
                        OP_READ: begin
                            if (idx_in_range) begin
                                state_reg <= ST_RDWAIT;
                            end
                        end
                        OP_CLEAR: begin
                            col_reg           <= '0;
                            row_reg           <= '0;
                            row_base_reg      <= '0;
                            sw_cmd_reg.go     <= 1'b1;
                            sw_cmd_reg.scroll <= 1'b0;
                            sw_cmd_reg.fill   <= {attr_reg, SPACE_CODE};
                            state_reg         <= ST_SWEEP;
                        end
                        default: begin
                            state_reg <= ST_RESULT;
                        end
                    endcase
                end
                ST_RDWAIT: begin
                    value_reg <= ram_rdata;
                    state_reg <= ST_RESULT;
                end
                ST_SWEEP: begin
                    if (sw_stat.done) begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg      <= 1'b1;
                        m_cursor_pos_reg <= pos_full[POS_W-1:0];
                        m_cell_value_reg <= value_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_cursor_pos = m_cursor_pos_reg;
    assign m_cell_value = m_cell_value_reg;

    a_idle_no_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !sw_stat.busy)
        else $error("sweep still running while taking items");

    a_single_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sw_we && top_we))
        else $error("sweep and cursor write collide on the screen RAM");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again before the item finished");

    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((CELLS > (1 << POS_W)) || (32'(m_cursor_pos) < CELLS)))
        else $error("cursor position beyond the screen");

    a_result_after_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP && sw_stat.done) |=> (state_reg == ST_RESULT))
        else $error("sweep completion lost");

endmodule
